/* hdl/dpid_pkg.sv */
package dpid_pkg;

    localparam int FRAC_BITS = 12;

    // Q24.8 half and full turn
    localparam logic signed [31:0] HALF_TURN = 32'sd46080;
    localparam logic signed [31:0] FULL_TURN = 32'sd92160;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] CMD_DIST  = 2'd0;
    localparam logic [1:0] CMD_TURN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] REG_DIST_GAIN_P = 3'd0;
    localparam logic [2:0] REG_DIST_GAIN_I = 3'd1;
    localparam logic [2:0] REG_DIST_GAIN_D = 3'd2;
    localparam logic [2:0] REG_DIST_LIMIT  = 3'd3;
    localparam logic [2:0] REG_TURN_GAIN_P = 3'd4;
    localparam logic [2:0] REG_TURN_GAIN_I = 3'd5;
    localparam logic [2:0] REG_TURN_GAIN_D = 3'd6;
    localparam logic [2:0] REG_TURN_LIMIT  = 3'd7;

    localparam logic [15:0] RST_DIST_GAIN_P = 16'd1024;
    localparam logic [15:0] RST_DIST_GAIN_I = 16'd123;
    localparam logic [15:0] RST_DIST_GAIN_D = 16'd819;
    localparam logic [30:0] RST_DIST_LIMIT  = 31'd12800;
    localparam logic [15:0] RST_TURN_GAIN_P = 16'd2048;
    localparam logic [15:0] RST_TURN_GAIN_I = 16'd164;
    localparam logic [15:0] RST_TURN_GAIN_D = 16'd819;
    localparam logic [30:0] RST_TURN_LIMIT  = 31'd12800;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] drive_value;
        logic               saturated;
    } t_out_req;

    // operands handed from the state update to the term sum
    typedef struct packed {
        logic               step;
        logic               turn;
        logic signed [31:0] err;
        logic signed [31:0] acc;
        logic signed [31:0] dif;
        logic               flag;
    } t_ops;

endpackage

/* hdl/dpid_update.sv */
module dpid_update import dpid_pkg::*; (
    input  t_in_req            i_req,
    input  logic signed [31:0] i_acc,
    input  logic signed [31:0] i_last,
    input  logic [30:0]        i_limit,
    output t_ops               o_ops
);

    logic signed [32:0] w_raw;
    logic signed [31:0] w_err_sat;
    logic               w_err_ovf;
    logic signed [31:0] w_err;
    logic signed [32:0] w_sum;
    logic signed [32:0] w_lim;
    logic signed [31:0] w_acc;
    logic signed [32:0] w_dif_raw;
    logic               w_dif_ovf;
    logic signed [31:0] w_dif;
    logic               w_turn;

    assign w_turn = (i_req.cmd == CMD_TURN);

    always_comb begin
        w_raw     = {i_req.setpoint[31], i_req.setpoint} - {i_req.measured[31], i_req.measured};
        w_err_ovf = (w_raw[32] != w_raw[31]);
        if (w_err_ovf) begin
            w_err_sat = w_raw[32] ? S32_MIN : S32_MAX;
        end else begin
            w_err_sat = w_raw[31:0];
        end
    end

    // heading wraps once into the half-turn window
    always_comb begin
        w_err = w_err_sat;
        if (w_turn && (w_err_sat > HALF_TURN)) begin
            w_err = w_err_sat - FULL_TURN;
        end else if (w_turn && (w_err_sat < -HALF_TURN)) begin
            w_err = w_err_sat + FULL_TURN;
        end
    end

    always_comb begin
        w_sum = {i_acc[31], i_acc} + {w_err[31], w_err};
        w_lim = {2'b00, i_limit};
        if (w_sum > w_lim) begin
            w_acc = w_lim[31:0];
        end else if (w_sum < -w_lim) begin
            w_acc = 32'(-w_lim);
        end else begin
            w_acc = w_sum[31:0];
        end
    end

    always_comb begin
        w_dif_raw = {w_err[31], w_err} - {i_last[31], i_last};
        w_dif_ovf = (w_dif_raw[32] != w_dif_raw[31]);
        if (w_dif_ovf) begin
            w_dif = w_dif_raw[32] ? S32_MIN : S32_MAX;
        end else begin
            w_dif = w_dif_raw[31:0];
        end
    end

    always_comb begin
        o_ops.step = (i_req.cmd == CMD_DIST) || w_turn;
        o_ops.turn = w_turn;
        o_ops.err  = w_err;
        o_ops.acc  = w_acc;
        o_ops.dif  = w_dif;
        o_ops.flag = w_err_ovf || w_dif_ovf;
    end

endmodule

/* hdl/dpid_terms.sv */
module dpid_terms import dpid_pkg::*; (
    input  t_ops        i_ops,
    input  logic [15:0] i_gain_p,
    input  logic [15:0] i_gain_i,
    input  logic [15:0] i_gain_d,
    output t_out_req    o_res
);

    logic signed [48:0] w_prod_p;
    logic signed [48:0] w_prod_i;
    logic signed [48:0] w_prod_d;
    logic signed [48:0] w_sh_p;
    logic signed [48:0] w_sh_i;
    logic signed [48:0] w_sh_d;
    logic signed [38:0] w_total;
    logic               w_ovf;

    assign w_prod_p = i_ops.err * $signed({1'b0, i_gain_p});
    assign w_prod_i = i_ops.acc * $signed({1'b0, i_gain_i});
    assign w_prod_d = i_ops.dif * $signed({1'b0, i_gain_d});

    // arithmetic shift gives floor division
    assign w_sh_p = w_prod_p >>> FRAC_BITS;
    assign w_sh_i = w_prod_i >>> FRAC_BITS;
    assign w_sh_d = w_prod_d >>> FRAC_BITS;

    assign w_total = w_sh_p[38:0] + w_sh_i[38:0] + w_sh_d[38:0];
    assign w_ovf   = (w_total > 39'(S32_MAX)) || (w_total < 39'(S32_MIN));

    always_comb begin
        if (!i_ops.step) begin
            o_res.drive_value = '0;
            o_res.saturated   = 1'b0;
        end else begin
            if (w_total > 39'(S32_MAX)) begin
                o_res.drive_value = S32_MAX;
            end else if (w_total < 39'(S32_MIN)) begin
                o_res.drive_value = S32_MIN;
            end else begin
                o_res.drive_value = w_total[31:0];
            end
            o_res.saturated = i_ops.flag || w_ovf;
        end
    end

endmodule

/* hdl/dual_pid_with_heading_wrap.sv */
// Pipeline: input register, then operand register after the state update,
//   then result register after the terms. Throughput: one request per cycle
//   unless the output stalls; the integral and last-error loop closes in the
//   state-update stage, so back-to-back steps on one channel need no wait.
// Reset: gains and limits take their defaults, all four state words clear,
//   pipeline empties.
module dual_pid_with_heading_wrap import dpid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_req
);

    logic [15:0]        r_dist_gp, r_dist_gi, r_dist_gd;
    logic [30:0]        r_dist_lim;
    logic [15:0]        r_turn_gp, r_turn_gi, r_turn_gd;
    logic [30:0]        r_turn_lim;

    logic signed [31:0] r_dist_acc, r_dist_last, r_turn_acc, r_turn_last;

    logic               r_in_valid;
    t_in_req            r_in;
    logic               r_op_valid;
    t_ops               r_op;
    logic               r_out_valid;
    t_out_req           r_out;

    logic               w_adv;
    logic               w_turn;
    logic signed [31:0] w_acc_sel, w_last_sel;
    logic [30:0]        w_lim_sel;
    t_ops               w_ops;
    t_out_req           w_res;
    logic [15:0]        w_gp, w_gi, w_gd;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    assign w_turn     = (r_in.cmd == CMD_TURN);
    assign w_acc_sel  = w_turn ? r_turn_acc  : r_dist_acc;
    assign w_last_sel = w_turn ? r_turn_last : r_dist_last;
    assign w_lim_sel  = w_turn ? r_turn_lim  : r_dist_lim;

    assign w_gp = r_op.turn ? r_turn_gp : r_dist_gp;
    assign w_gi = r_op.turn ? r_turn_gi : r_dist_gi;
    assign w_gd = r_op.turn ? r_turn_gd : r_dist_gd;

    dpid_update u_update (
        .i_req   (r_in),
        .i_acc   (w_acc_sel),
        .i_last  (w_last_sel),
        .i_limit (w_lim_sel),
        .o_ops   (w_ops)
    );

    dpid_terms u_terms (
        .i_ops    (r_op),
        .i_gain_p (w_gp),
        .i_gain_i (w_gi),
        .i_gain_d (w_gd),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gp  <= RST_DIST_GAIN_P;
            r_dist_gi  <= RST_DIST_GAIN_I;
            r_dist_gd  <= RST_DIST_GAIN_D;
            r_dist_lim <= RST_DIST_LIMIT;
            r_turn_gp  <= RST_TURN_GAIN_P;
            r_turn_gi  <= RST_TURN_GAIN_I;
            r_turn_gd  <= RST_TURN_GAIN_D;
            r_turn_lim <= RST_TURN_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIST_GAIN_P: r_dist_gp  <= i_cfg_data[15:0];
                REG_DIST_GAIN_I: r_dist_gi  <= i_cfg_data[15:0];
                REG_DIST_GAIN_D: r_dist_gd  <= i_cfg_data[15:0];
                REG_DIST_LIMIT:  r_dist_lim <= i_cfg_data;
                REG_TURN_GAIN_P: r_turn_gp  <= i_cfg_data[15:0];
                REG_TURN_GAIN_I: r_turn_gi  <= i_cfg_data[15:0];
                REG_TURN_GAIN_D: r_turn_gd  <= i_cfg_data[15:0];
                REG_TURN_LIMIT:  r_turn_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel state moves as the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_acc  <= '0;
            r_dist_last <= '0;
            r_turn_acc  <= '0;
            r_turn_last <= '0;
        end else if (w_adv && r_in_valid) begin
            case (r_in.cmd)
                CMD_DIST: begin
                    r_dist_acc  <= w_ops.acc;
                    r_dist_last <= w_ops.err;
                end
                CMD_TURN: begin
                    r_turn_acc  <= w_ops.acc;
                    r_turn_last <= w_ops.err;
                end
                CMD_CLEAR: begin
                    r_dist_acc  <= '0;
                    r_dist_last <= '0;
                    r_turn_acc  <= '0;
                    r_turn_last <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_op_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid  <= i_in_valid;
            r_op_valid  <= r_in_valid;
            r_out_valid <= r_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in  <= i_in_req;
            r_op  <= w_ops;
            r_out <= w_res;
        end
    end

endmodule
